// ----- sv/zbtp_pkg.sv -----
// shared types, codes and the shade ramp for the torus point plotter
// no dependencies
package zbtp_pkg;

    localparam int VAL_W = 48;
    localparam int OP_W  = 34;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [OP_W-1:0]  t_opnd;
    typedef logic [4:0]              t_op;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_PLOT  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // register indexes on the write port
    localparam logic [1:0] CFG_COS_A = 2'd0;
    localparam logic [1:0] CFG_SIN_A = 2'd1;
    localparam logic [1:0] CFG_COS_B = 2'd2;
    localparam logic [1:0] CFG_SIN_B = 2'd3;

    // multiply steps, in issue order
    localparam t_op OP_XA0   = 5'd0;
    localparam t_op OP_SASB  = 5'd1;
    localparam t_op OP_XA    = 5'd2;
    localparam t_op OP_CYCA  = 5'd3;
    localparam t_op OP_XB    = 5'd4;
    localparam t_op OP_X     = 5'd5;
    localparam t_op OP_YA0   = 5'd6;
    localparam t_op OP_SACB  = 5'd7;
    localparam t_op OP_YA    = 5'd8;
    localparam t_op OP_YB    = 5'd9;
    localparam t_op OP_Y     = 5'd10;
    localparam t_op OP_CACX  = 5'd11;
    localparam t_op OP_ZA    = 5'd12;
    localparam t_op OP_Z     = 5'd13;
    localparam t_op OP_CPHCT = 5'd14;
    localparam t_op OP_L0    = 5'd15;
    localparam t_op OP_CACT  = 5'd16;
    localparam t_op OP_L1    = 5'd17;
    localparam t_op OP_L2    = 5'd18;
    localparam t_op OP_CAST  = 5'd19;
    localparam t_op OP_CTSA  = 5'd20;
    localparam t_op OP_LA    = 5'd21;
    localparam t_op OP_L     = 5'd22;
    localparam t_op OP_PX    = 5'd23;
    localparam t_op OP_PY    = 5'd24;
    localparam t_op OP_NCOL  = 5'd25;
    localparam t_op OP_NROW  = 5'd26;

    localparam logic [6:0] CHAR_SPACE = 7'h20;

    typedef struct packed {
        logic cap;
        logic mul;
        logic wb;
        t_op  step;
        logic div_init;
        logic div_step;
        logic eval;
        logic upd;
        logic rd_addr;
        logic rd_fin;
        logic clr_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_stat;

    function automatic logic [6:0] ramp_char(input logic [3:0] s);
        logic [6:0] c;
        case (s)
            4'd0, 4'd12: c = 7'h2E;
            4'd1, 4'd13: c = 7'h2C;
            4'd2, 4'd14: c = 7'h2D;
            4'd3, 4'd15: c = 7'h7E;
            4'd4:        c = 7'h3A;
            4'd5:        c = 7'h3B;
            4'd6:        c = 7'h3D;
            4'd7:        c = 7'h21;
            4'd8:        c = 7'h2A;
            4'd9:        c = 7'h23;
            4'd10:       c = 7'h24;
            4'd11:       c = 7'h40;
            default:     c = 7'h40;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/zbtp_in_if.sv -----
// input channel: action word with trig samples and read cell
// no dependencies
interface zbtp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] cos_tube;
    logic signed [15:0] sin_tube;
    logic signed [15:0] cos_phi;
    logic signed [15:0] sin_phi;
    logic [4:0]         read_col;
    logic [4:0]         read_row;

    modport source (output valid, action, cos_tube, sin_tube, cos_phi, sin_phi,
                    read_col, read_row, input ready);
    modport sink (input valid, action, cos_tube, sin_tube, cos_phi, sin_phi,
                  read_col, read_row, output ready);
endinterface

// ----- sv/zbtp_out_if.sv -----
// output channel: shade character and plotted flag
// no dependencies
interface zbtp_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] shade_char;
    logic       plotted;

    modport source (output valid, shade_char, plotted, input ready);
    modport sink (input valid, shade_char, plotted, output ready);
endinterface

// ----- sv/zbuffer_torus_point_plotter.sv -----
// plot item: 27 multiplies on one shared multiplier, a 16-step reciprocal divider,
// then a memory read and write; read item: address, memory read, result
// clear item: every cell zeroed, one cell written per cycle on the single port
// one item in flight; the next is taken once the result sits in the output register
// reset (synchronous, active low) restores the angle registers and runs the same
// clearing sweep over all cells before the first word is accepted
module zbuffer_torus_point_plotter #(
    parameter int GRID_W    = 25,
    parameter int GRID_H    = 25,
    parameter int FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zbtp_in_if.sink     i_item,
    zbtp_out_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import zbtp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    zbtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_action    (i_item.action),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    zbtp_dp #(
        .GRID_W    (GRID_W),
        .GRID_H    (GRID_H),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_item.action),
        .i_cos_tube   (i_item.cos_tube),
        .i_sin_tube   (i_item.sin_tube),
        .i_cos_phi    (i_item.cos_phi),
        .i_sin_phi    (i_item.sin_phi),
        .i_read_col   (i_item.read_col),
        .i_read_row   (i_item.read_row),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_shade_char (o_res.shade_char),
        .o_plotted    (o_res.plotted)
    );

endmodule

// ----- sv/zbtp_ctrl.sv -----
// sequencer for the plotter: clear sweep, multiply steps, divider, memory access
// depends on zbtp_pkg
module zbtp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_action,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  zbtp_pkg::t_stat i_stat,
    output zbtp_pkg::t_cmd  o_cmd
);
    import zbtp_pkg::*;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_WB    = 4'd3;
    localparam logic [3:0] ST_DINIT = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_EVAL  = 4'd6;
    localparam logic [3:0] ST_MRD   = 4'd7;
    localparam logic [3:0] ST_UPD   = 4'd8;
    localparam logic [3:0] ST_RADDR = 4'd9;
    localparam logic [3:0] ST_RMRD  = 4'd10;
    localparam logic [3:0] ST_RFIN  = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    logic [3:0] r_state, n_state;
    t_op        r_step, n_step;
    logic [3:0] r_cnt, n_cnt;
    logic       r_after, n_after;
    logic       r_ovalid, n_ovalid;
    logic       accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_after  = r_after;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.step = r_step;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_after ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.cap = 1'b1;
                    n_step    = OP_XA0;
                    case (i_action)
                        ACT_CLEAR: begin
                            n_state = ST_CLR;
                            n_after = 1'b1;
                        end
                        ACT_PLOT: n_state = ST_MUL;
                        ACT_READ: n_state = ST_RADDR;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_WB;
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                n_step   = t_op'(r_step + 5'd1);
                if (r_step == OP_L) begin
                    n_state = ST_DINIT;
                end else if (r_step == OP_NROW) begin
                    n_state = ST_EVAL;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = ST_MUL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = ST_MRD;
            end
            ST_MRD:  n_state = ST_UPD;
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = ST_DONE;
            end
            ST_RADDR: begin
                o_cmd.rd_addr = 1'b1;
                n_state = ST_RMRD;
            end
            ST_RMRD: n_state = ST_RFIN;
            ST_RFIN: begin
                o_cmd.rd_fin = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_step   <= OP_XA0;
            r_cnt    <= '0;
            r_after  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_after  <= n_after;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ----- sv/zbtp_dp.sv -----
// datapath: angle registers, shared multiplier, reciprocal divider, cell memory
// depends on zbtp_pkg
module zbtp_dp #(
    parameter int GRID_W    = 25,
    parameter int GRID_H    = 25,
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  zbtp_pkg::t_cmd     i_cmd,
    output zbtp_pkg::t_stat    o_stat,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_cos_tube,
    input  logic signed [15:0] i_sin_tube,
    input  logic signed [15:0] i_cos_phi,
    input  logic signed [15:0] i_sin_phi,
    input  logic [4:0]         i_read_col,
    input  logic [4:0]         i_read_row,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic [6:0]         o_shade_char,
    output logic               o_plotted
);
    import zbtp_pkg::*;

    localparam int CELLS  = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [15:0] TRIG_ONE = 16'(64'd1 << FRAC_BITS);
    localparam t_val  ONE     = t_val'(64'd1 << FRAC_BITS);
    localparam t_val  K2_ONE  = t_val'(64'd5 << FRAC_BITS);
    localparam t_val  DEN     = t_val'(64'd24 << FRAC_BITS);
    localparam t_val  NEG_DEN = -DEN;
    localparam t_val  W_DEN   = t_val'(64'(GRID_W) * (64'd24 << FRAC_BITS));
    localparam t_val  H_DEN   = t_val'(64'(GRID_H) * (64'd24 << FRAC_BITS));
    localparam t_val  COLBASE = t_val'(64'(GRID_W / 2) * (64'd24 << FRAC_BITS));
    localparam t_val  ROWBASE = t_val'(64'(GRID_H / 2) * (64'd24 << FRAC_BITS));
    localparam t_opnd NUM     = t_opnd'(GRID_W * 15);

    // angle registers
    logic signed [15:0] r_ca, r_sa, r_cb, r_sb;
    // sample registers
    logic signed [15:0] r_ct, r_st, r_cph, r_sph;
    logic [4:0]         r_rcol, r_rrow;
    t_val               r_cx, r_u, r_v, r_w, r_x, r_y, r_z, r_l;
    logic signed [2*OP_W-1:0] r_prod;
    logic [VAL_W-1:0]   r_rem;
    logic [15:0]        r_q;
    logic               r_sat, r_drop, r_ok;
    logic [ADDR_W-1:0]  r_addr, r_clr;
    logic [19:0]        mem [CELLS];
    logic [19:0]        r_rdata;
    logic [6:0]         r_res_char, r_o_char;
    logic               r_res_plot, r_o_plot;

    t_opnd       op_a, op_b;
    t_val        m, mw;
    logic [15:0] ooz;
    logic [VAL_W:0] rem2;
    logic [VAL_W:0] zu;
    t_val        ncp, nrp;
    logic [8:0]  mc, mr;
    logic [17:0] cprod, rprod;
    logic [7:0]  col8, row8;
    logic        col_ok, row_ok;
    t_val        lsh;
    logic [3:0]  shade;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [19:0] mem_wd;

    assign o_stat.clr_last = (32'(r_clr) == CELLS - 1);
    assign o_shade_char    = r_o_char;
    assign o_plotted       = r_o_plot;

    assign m    = t_val'(r_prod >>> FRAC_BITS);
    assign mw   = t_val'(r_prod);
    assign ooz  = r_sat ? 16'hFFFF : r_q;
    assign rem2 = {r_rem, 1'b0};
    assign zu   = {1'b0, r_z};

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.step)
            OP_XA0:   begin op_a = t_opnd'(r_cb);  op_b = t_opnd'(r_cph); end
            OP_SASB:  begin op_a = t_opnd'(r_sa);  op_b = t_opnd'(r_sb);  end
            OP_XA:    begin op_a = t_opnd'(r_v);   op_b = t_opnd'(r_sph); end
            OP_CYCA:  begin op_a = t_opnd'(r_st);  op_b = t_opnd'(r_ca);  end
            OP_XB:    begin op_a = t_opnd'(r_w);   op_b = t_opnd'(r_sb);  end
            OP_X:     begin op_a = t_opnd'(r_cx);  op_b = t_opnd'(r_u);   end
            OP_YA0:   begin op_a = t_opnd'(r_sb);  op_b = t_opnd'(r_cph); end
            OP_SACB:  begin op_a = t_opnd'(r_sa);  op_b = t_opnd'(r_cb);  end
            OP_YA:    begin op_a = t_opnd'(r_v);   op_b = t_opnd'(r_sph); end
            OP_YB:    begin op_a = t_opnd'(r_w);   op_b = t_opnd'(r_cb);  end
            OP_Y:     begin op_a = t_opnd'(r_cx);  op_b = t_opnd'(r_u);   end
            OP_CACX:  begin op_a = t_opnd'(r_ca);  op_b = t_opnd'(r_cx);  end
            OP_ZA:    begin op_a = t_opnd'(r_u);   op_b = t_opnd'(r_sph); end
            OP_Z:     begin op_a = t_opnd'(r_st);  op_b = t_opnd'(r_sa);  end
            OP_CPHCT: begin op_a = t_opnd'(r_cph); op_b = t_opnd'(r_ct);  end
            OP_L0:    begin op_a = t_opnd'(r_u);   op_b = t_opnd'(r_sb);  end
            OP_CACT:  begin op_a = t_opnd'(r_ca);  op_b = t_opnd'(r_ct);  end
            OP_L1:    begin op_a = t_opnd'(r_u);   op_b = t_opnd'(r_sph); end
            OP_L2:    begin op_a = t_opnd'(r_sa);  op_b = t_opnd'(r_st);  end
            OP_CAST:  begin op_a = t_opnd'(r_ca);  op_b = t_opnd'(r_st);  end
            OP_CTSA:  begin op_a = t_opnd'(r_ct);  op_b = t_opnd'(r_sa);  end
            OP_LA:    begin op_a = t_opnd'(r_v);   op_b = t_opnd'(r_sph); end
            OP_L:     begin op_a = t_opnd'(r_cb);  op_b = t_opnd'(r_u);   end
            OP_PX:    begin op_a = t_opnd'($signed({1'b0, ooz})); op_b = t_opnd'(r_x); end
            OP_PY:    begin op_a = t_opnd'($signed({1'b0, ooz})); op_b = t_opnd'(r_y); end
            OP_NCOL:  begin op_a = NUM;            op_b = t_opnd'(r_u);   end
            OP_NROW:  begin op_a = NUM;            op_b = t_opnd'(r_v);   end
            default:  begin op_a = '0;             op_b = '0;             end
        endcase
    end

    // cell from projected numerator: floor(n / (3 * 2^(F+3))), with n in (-den, 0) giving 0
    always_comb begin
        ncp    = r_x[VAL_W-1] ? '0 : r_x;
        nrp    = r_y[VAL_W-1] ? '0 : r_y;
        mc     = ncp[FRAC_BITS+3 +: 9];
        mr     = nrp[FRAC_BITS+3 +: 9];
        cprod  = 18'(mc) * 18'd171;
        rprod  = 18'(mr) * 18'd171;
        col8   = cprod[16:9];
        row8   = rprod[16:9];
        col_ok = (r_x > NEG_DEN) && (r_x < W_DEN);
        row_ok = (r_y > NEG_DEN) && (r_y < H_DEN);
        lsh    = r_l >>> (FRAC_BITS - 3);
        shade  = (lsh > t_val'(11)) ? 4'd11 : lsh[3:0];
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = {ooz, shade};
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '0;
        end else if (i_cmd.upd && r_ok && (ooz > r_rdata[19:4])) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca  <= TRIG_ONE;
            r_sa  <= '0;
            r_cb  <= TRIG_ONE;
            r_sb  <= '0;
            r_clr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COS_A: r_ca <= i_cfg_data;
                    CFG_SIN_A: r_sa <= i_cfg_data;
                    CFG_COS_B: r_cb <= i_cfg_data;
                    CFG_SIN_B: r_sb <= i_cfg_data;
                    default:   r_ca <= r_ca;
                endcase
            end
            if (i_cmd.cap) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= ADDR_W'(r_clr + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_ct       <= i_cos_tube;
            r_st       <= i_sin_tube;
            r_cph      <= i_cos_phi;
            r_sph      <= i_sin_phi;
            r_rcol     <= i_read_col;
            r_rrow     <= i_read_row;
            r_cx       <= (ONE <<< 1) + t_val'(i_cos_tube);
            r_res_char <= (i_action == ACT_READ) ? CHAR_SPACE : 7'd0;
            r_res_plot <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.wb) begin
            case (i_cmd.step)
                OP_XA0:   r_u <= m;
                OP_SASB:  r_v <= m;
                OP_XA:    r_u <= r_u + m;
                OP_CYCA:  r_w <= m;
                OP_XB:    r_v <= m;
                OP_X:     r_x <= m - r_v;
                OP_YA0:   r_u <= m;
                OP_SACB:  r_v <= m;
                OP_YA:    r_u <= r_u - m;
                OP_YB:    r_v <= m;
                OP_Y:     r_y <= m + r_v;
                OP_CACX:  r_u <= m;
                OP_ZA:    r_v <= m;
                OP_Z:     r_z <= K2_ONE + r_v + m;
                OP_CPHCT: r_u <= m;
                OP_L0:    r_l <= m;
                OP_CACT:  r_u <= m;
                OP_L1:    r_l <= r_l - m;
                OP_L2:    r_l <= r_l - m;
                OP_CAST:  r_u <= m;
                OP_CTSA:  r_v <= m;
                OP_LA:    r_u <= r_u - m;
                OP_L:     r_l <= r_l + m;
                OP_PX:    r_u <= t_val'(r_prod >>> 16);
                OP_PY:    r_v <= t_val'(r_prod >>> 16);
                OP_NCOL:  r_x <= COLBASE + mw;
                OP_NROW:  r_y <= ROWBASE - mw;
                default:  r_u <= r_u;
            endcase
        end
        // 2^(16+F)/z: saturates when z <= 2^F, else 16 restoring steps from 2^F
        if (i_cmd.div_init) begin
            r_drop <= (r_z <= t_val'(0));
            r_sat  <= (r_z <= ONE);
            r_rem  <= VAL_W'(ONE);
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            if (rem2 >= zu) begin
                r_rem <= VAL_W'(rem2 - zu);
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= VAL_W'(rem2);
                r_q   <= {r_q[14:0], 1'b0};
            end
        end
        if (i_cmd.eval) begin
            r_ok   <= !r_drop && (r_l > t_val'(0)) && col_ok && row_ok;
            r_addr <= ADDR_W'(32'(row8) * GRID_W + 32'(col8));
        end
        if (i_cmd.rd_addr) begin
            r_ok   <= (32'(r_rcol) < GRID_W) && (32'(r_rrow) < GRID_H);
            r_addr <= ADDR_W'(32'(r_rrow) * GRID_W + 32'(r_rcol));
        end
        if (i_cmd.upd && mem_we) begin
            r_res_plot <= 1'b1;
        end
        if (i_cmd.rd_fin && r_ok && (r_rdata[19:4] != 16'd0)) begin
            r_res_char <= ramp_char(r_rdata[3:0]);
        end
        if (i_cmd.out_load) begin
            r_o_char <= r_res_char;
            r_o_plot <= r_res_plot;
        end
    end

endmodule

// ----- tb/zbtp_plot_checker.sv -----
// scoreboard for the torus point plotter: mirrors depth and shade stores,
// predicts each result word and compares it; depends on zbtp_pkg and both channel interfaces
module zbtp_plot_checker #(
    parameter int GRID_W    = 25,
    parameter int GRID_H    = 25,
    parameter int FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zbtp_in_if          i_item,
    zbtp_out_if         o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_cnt,
    output int          o_pending,
    output int          o_words_in,
    output int          o_words_out,
    output int          o_plots_hit
);
    import zbtp_pkg::*;

    localparam int CELLS = GRID_W * GRID_H;

    typedef struct packed {
        logic [6:0] shade_char;
        logic       plotted;
    } t_res;

    logic [15:0] depth_mirror [CELLS];
    logic [3:0]  shade_mirror [CELLS];
    logic signed [15:0] cos_a, sin_a, cos_b, sin_b;
    t_res expected_q [$];

    // floor division by 2^n
    function automatic longint fx_shr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return fx_shr(a * b, FRAC_BITS);
    endfunction

    function automatic logic [6:0] shade_to_char(input logic [3:0] s);
        case (s % 12)
            0: return 7'h2E;   1: return 7'h2C;   2: return 7'h2D;   3: return 7'h7E;
            4: return 7'h3A;   5: return 7'h3B;   6: return 7'h3D;   7: return 7'h21;
            8: return 7'h2A;   9: return 7'h23;   10: return 7'h24;  default: return 7'h40;
        endcase
    endfunction

    // surface sample: returns 1 when a cell took the point
    function automatic logic plot_sample(input longint ct, input longint st,
                                         input longint cph, input longint sph);
        longint one, ca, sa, cb, sb, cx, cy, x, y, z, ooz, px, py, num, den;
        longint col, row, lum, shade;
        int idx;
        one = longint'(1) << FRAC_BITS;
        ca = cos_a; sa = sin_a; cb = cos_b; sb = sin_b;
        cx = 2 * one + ct;
        cy = st;
        x = fmul(cx, fmul(cb, cph) + fmul(fmul(sa, sb), sph)) - fmul(fmul(cy, ca), sb);
        y = fmul(cx, fmul(sb, cph) - fmul(fmul(sa, cb), sph)) + fmul(fmul(cy, ca), cb);
        z = 5 * one + fmul(fmul(ca, cx), sph) + fmul(cy, sa);
        if (z <= 0) return 1'b0;
        ooz = (longint'(1) << (16 + FRAC_BITS)) / z;
        if (ooz > 65535) ooz = 65535;
        num = longint'(GRID_W) * 15;
        den = 24 * one;
        px = fx_shr(ooz * x, 16);
        py = fx_shr(ooz * y, 16);
        col = (longint'(GRID_W / 2) * den + num * px) / den;
        row = (longint'(GRID_H / 2) * den - num * py) / den;
        lum = fmul(fmul(cph, ct), sb) - fmul(fmul(ca, ct), sph) - fmul(sa, st)
              + fmul(cb, fmul(ca, st) - fmul(fmul(ct, sa), sph));
        if (lum <= 0) return 1'b0;
        if (col < 0 || col >= GRID_W || row < 0 || row >= GRID_H) return 1'b0;
        idx = int'(row * GRID_W + col);
        if (longint'(depth_mirror[idx]) >= ooz) return 1'b0;
        shade = (8 * lum) >>> FRAC_BITS;
        if (shade > 11) shade = 11;
        depth_mirror[idx] = ooz[15:0];
        shade_mirror[idx] = shade[3:0];
        return 1'b1;
    endfunction

    function automatic t_res predict_word(input logic [1:0] act, input logic signed [15:0] ct,
                                          input logic signed [15:0] st,
                                          input logic signed [15:0] cph,
                                          input logic signed [15:0] sph,
                                          input logic [4:0] col, input logic [4:0] row);
        t_res r;
        r = '0;
        case (act)
            ACT_CLEAR: begin
                foreach (depth_mirror[i]) depth_mirror[i] = '0;
            end
            ACT_PLOT: begin
                r.plotted = plot_sample(ct, st, cph, sph);
            end
            ACT_READ: begin
                r.shade_char = CHAR_SPACE;
                if (col < GRID_W && row < GRID_H && depth_mirror[row * GRID_W + col] != 0)
                    r.shade_char = shade_to_char(shade_mirror[row * GRID_W + col]);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res exp_w;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (depth_mirror[i]) begin
                depth_mirror[i] = '0;
                shade_mirror[i] = '0;
            end
            cos_a = 16'(1 << FRAC_BITS); sin_a = '0;
            cos_b = 16'(1 << FRAC_BITS); sin_b = '0;
            expected_q.delete();
            o_fail_cnt <= 0;
            o_pending <= 0;
            o_words_in <= 0;
            o_words_out <= 0;
            o_plots_hit <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COS_A: cos_a = i_cfg_data;
                    CFG_SIN_A: sin_a = i_cfg_data;
                    CFG_COS_B: cos_b = i_cfg_data;
                    default:   sin_b = i_cfg_data;
                endcase
            end
            if (o_res.valid && o_res.ready) begin
                o_words_out <= o_words_out + 1;
                if (o_res.plotted) o_plots_hit <= o_plots_hit + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result word");
                    errs = errs + 1;
                end else begin
                    exp_w = expected_q.pop_front();
                    if (exp_w.shade_char !== o_res.shade_char) begin
                        $error("shade_char: expected %h, got %h", exp_w.shade_char,
                               o_res.shade_char);
                        errs = errs + 1;
                    end
                    if (exp_w.plotted !== o_res.plotted) begin
                        $error("plotted: expected %0d, got %0d", exp_w.plotted, o_res.plotted);
                        errs = errs + 1;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                o_words_in <= o_words_in + 1;
                expected_q.push_back(predict_word(i_item.action, i_item.cos_tube,
                    i_item.sin_tube, i_item.cos_phi, i_item.sin_phi,
                    i_item.read_col, i_item.read_row));
            end
            o_fail_cnt <= o_fail_cnt + errs;
            o_pending <= expected_q.size();
        end
    end

endmodule

// ----- tb/tb_zbuffer_torus_point_plotter.sv -----
// stimulus and verdict for the torus point plotter: angle settings, directed
// and random words, idle/stall phases; depends on zbtp_pkg, interfaces, zbtp_plot_checker
module tb_zbuffer_torus_point_plotter;
    import zbtp_pkg::*;

    localparam int CLR_CYCLES = 700;
    localparam int WD_LIMIT   = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    int fail_cnt, pending, words_in, words_out, plots_hit;
    int send_idle_pct, recv_stall_pct, quiet_cycles;

    zbtp_in_if  item_ch ();
    zbtp_out_if res_ch ();

    zbuffer_torus_point_plotter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_res(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    zbtp_plot_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch), .o_res(res_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_words_in(words_in),
        .o_words_out(words_out), .o_plots_hit(plots_hit)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("timeout with %0d words outstanding", pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_trig();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // raw 16-bit noise one time in four, else a trig sample, so every input bit toggles
    function automatic logic signed [15:0] rand_any();
        return $urandom_range(3) == 0 ? 16'($urandom) : rand_trig();
    endfunction

    task automatic send_word(input logic [1:0] act, input logic signed [15:0] ct,
                             input logic signed [15:0] st, input logic signed [15:0] cph,
                             input logic signed [15:0] sph, input logic [4:0] col,
                             input logic [4:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.action   <= act;
        item_ch.cos_tube <= ct;
        item_ch.sin_tube <= st;
        item_ch.cos_phi  <= cph;
        item_ch.sin_phi  <= sph;
        item_ch.read_col <= col;
        item_ch.read_row <= row;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_plot(input int ang_t, input int ang_p);
        real t, p;
        t = ang_t * 0.0628;
        p = ang_p * 0.0628;
        send_word(ACT_PLOT, 16'($rtoi($cos(t) * 16384.0)), 16'($rtoi($sin(t) * 16384.0)),
                  16'($rtoi($cos(p) * 16384.0)), 16'($rtoi($sin(p) * 16384.0)), 5'd0, 5'd0);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (CLR_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_angles(input real a, input real b);
        cfg_write(CFG_COS_A, 16'($rtoi($cos(a) * 16384.0)));
        cfg_write(CFG_SIN_A, 16'($rtoi($sin(a) * 16384.0)));
        cfg_write(CFG_COS_B, 16'($rtoi($cos(b) * 16384.0)));
        cfg_write(CFG_SIN_B, 16'($rtoi($sin(b) * 16384.0)));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly plots of a dense frame, interleaved with reads of the picture, with noise
    task automatic frame_burst(input int n);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0: send_word(ACT_CLEAR, rand_any(), rand_any(), rand_any(), rand_any(),
                             5'($urandom), 5'($urandom));
                1: send_word(ACT_NONE, rand_any(), rand_any(), rand_any(), rand_any(),
                             5'($urandom), 5'($urandom));
                2, 3: send_word(ACT_PLOT, rand_any(), rand_any(), rand_any(), rand_any(),
                                5'($urandom), 5'($urandom));
                4, 5, 6, 7, 8: send_word(ACT_READ, rand_any(), rand_any(), rand_any(),
                                         rand_any(), 5'($urandom), 5'($urandom));
                default: send_plot($urandom_range(99), $urandom_range(99));
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        item_ch.valid = 1'b0; item_ch.action = '0;
        item_ch.cos_tube = '0; item_ch.sin_tube = '0;
        item_ch.cos_phi = '0; item_ch.sin_phi = '0;
        item_ch.read_col = '0; item_ch.read_row = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset angles, extremes, back face, saturation, reads off grid
        send_word(ACT_READ, '0, '0, '0, '0, 5'd12, 5'd12);
        send_word(ACT_PLOT, 16'sd16384, '0, 16'sd16384, '0, 5'd0, 5'd0);
        send_word(ACT_PLOT, 16'sd16384, '0, 16'sd16384, '0, 5'd0, 5'd0);
        send_word(ACT_PLOT, -16'sd16384, '0, 16'sd16384, '0, 5'd0, 5'd0);
        send_word(ACT_PLOT, '0, 16'sd16384, '0, 16'sd16384, 5'd0, 5'd0);
        send_word(ACT_PLOT, '0, -16'sd16384, '0, -16'sd16384, 5'd0, 5'd0);
        send_word(ACT_PLOT, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 5'd0, 5'd0);
        send_word(ACT_PLOT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 5'd0, 5'd0);
        send_word(ACT_PLOT, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 5'd0, 5'd0);
        send_word(ACT_READ, '0, '0, '0, '0, 5'd31, 5'd0);
        send_word(ACT_READ, '0, '0, '0, '0, 5'd0, 5'd31);
        send_word(ACT_READ, '0, '0, '0, '0, 5'd24, 5'd24);
        send_word(ACT_NONE, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 5'd31, 5'd31);
        send_word(ACT_CLEAR, '0, '0, '0, '0, 5'd0, 5'd0);
        send_word(ACT_READ, '0, '0, '0, '0, 5'd12, 5'd12);
        drain();

        // rotation settings incl. extremes, each paired with one of four idle/stall profiles
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_angles(0.0, 3.14159265);
                1: set_angles(1.5707963, 1.5707963);
                2: set_angles(-1.5707963, -1.5707963);
                3: set_angles(3.14159265, 0.0);
                default: set_angles($urandom_range(628) / 100.0, $urandom_range(628) / 100.0);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            send_word(ACT_CLEAR, '0, '0, '0, '0, 5'd0, 5'd0);
            frame_burst(170);
            drain();
        end

        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (20) @(posedge i_clk);
        $display("sent %0d words, checked %0d results, %0d plots landed in a cell",
                 words_in, words_out, plots_hit);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/zbtp_pkg.sv
sv/zbtp_in_if.sv
sv/zbtp_out_if.sv
sv/zbtp_ctrl.sv
sv/zbtp_dp.sv
sv/zbuffer_torus_point_plotter.sv
tb/zbtp_plot_checker.sv
tb/tb_zbuffer_torus_point_plotter.sv
